/* rtl/sqh_pkg.sv */
// Package with widths and stage types for the square-to-quad homography pipeline.
`timescale 1ns / 1ps
`default_nettype none
package sqh_pkg;
    localparam int CW    = 32;        // coordinate width
    localparam int FB    = 16;        // fraction bits
    localparam int DW    = CW + 1;    // single difference
    localparam int CDW   = CW + 2;    // double difference
    localparam int PW    = DW + CDW;  // product of two differences
    localparam int NW    = PW + 1;    // difference of two products
    localparam int QB    = CW;        // quotient bits kept by the divider
    localparam int RW    = NW + QB;   // divider remainder width
    localparam int MW    = 2 * CW;    // coefficient times coordinate
    localparam int TW    = MW - FB;   // rescaled product
    localparam int SW    = TW + 1;    // sum before saturation
    localparam int NST   = 40;        // pipeline stages
    localparam int DIV0  = 4;         // first divider stage

    typedef struct packed {
        logic signed [CW-1:0] x00;
        logic signed [CW-1:0] y00;
        logic signed [CW-1:0] x10;
        logic signed [CW-1:0] y10;
        logic signed [CW-1:0] x01;
        logic signed [CW-1:0] y01;
    } cor_t;

    typedef struct packed {
        logic signed [DW-1:0]  a;
        logic signed [DW-1:0]  b;
        logic signed [CDW-1:0] c;
        logic signed [DW-1:0]  d;
        logic signed [DW-1:0]  e;
        logic signed [CDW-1:0] f;
        cor_t                  cor;
    } dif_t;

    typedef struct packed {
        logic signed [PW-1:0] bd;
        logic signed [PW-1:0] ae;
        logic signed [PW-1:0] cd;
        logic signed [PW-1:0] af;
        logic signed [PW-1:0] bf;
        logic signed [PW-1:0] ce;
        cor_t                 cor;
    } prd_t;

    typedef struct packed {
        logic signed [NW-1:0] det;
        logic signed [NW-1:0] n32;
        logic signed [NW-1:0] n31;
        cor_t                 cor;
    } num_t;

    typedef struct packed {
        logic [NW-1:0] dmag;
        logic [RW-1:0] rem32;
        logic [RW-1:0] rem31;
        logic [QB-1:0] q32;
        logic [QB-1:0] q31;
        logic          neg32;
        logic          neg31;
        logic          big32;
        logic          big31;
        logic          degen;
        cor_t          cor;
    } div_t;

    typedef struct packed {
        logic signed [CW-1:0] h31;
        logic signed [CW-1:0] h32;
        logic                 ovf;
        logic                 degen;
        cor_t                 cor;
    } hsat_t;

    typedef struct packed {
        logic signed [MW-1:0] p11;
        logic signed [MW-1:0] p12;
        logic signed [MW-1:0] p21;
        logic signed [MW-1:0] p22;
        logic signed [CW-1:0] h31;
        logic signed [CW-1:0] h32;
        logic                 ovf;
        logic                 degen;
        cor_t                 cor;
    } hmul_t;

    typedef struct packed {
        logic signed [SW-1:0] s11;
        logic signed [SW-1:0] s12;
        logic signed [SW-1:0] s21;
        logic signed [SW-1:0] s22;
        logic signed [CW-1:0] h31;
        logic signed [CW-1:0] h32;
        logic                 ovf;
        logic                 degen;
        cor_t                 cor;
    } hsum_t;
endpackage
`default_nettype wire

/* rtl/square_to_quad_homography.sv */
// Top level: fully pipelined square-to-quad projective coefficient unit.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Ports                      Content
// s_        in   s_tvalid s_tready s_tdata  eight corner coordinates, signed Q16.16
// m_        out  m_tvalid m_tready m_tdata  eight coefficients, signed Q16.16
//                m_tuser                    degenerate and overflow flags
//
// The pipeline is 40 stages deep; one item can enter every cycle unless the
// pipeline is full and the output side stalls.
// The depth is set by the two divider chains, which resolve one quotient bit per
// stage for 32 stages; differences, products and saturation take the other eight.
// Each stage holds its item until the next stage is free, so empty stages are
// filled while the output waits and a stall neither drops nor repeats an item.
// Reset clears only the valid bits; data registers are loaded as items pass.
module square_to_quad_homography (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // corner00_x, corner00_y, corner10_x, corner10_y,
    // corner01_x, corner01_y, corner11_x, corner11_y (32 bits each, lowest first)
    input  wire logic [255:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m11, m12, m13, m21, m22, m23, m31, m32 (32 bits each, lowest first)
    output logic [255:0]      m_tdata,
    // degenerate, overflow (lowest first)
    output logic [1:0]        m_tuser
);
    localparam int CW = sqh_pkg::CW;

    // Valid bit per stage and the advance chain: a stage may load when it is empty
    // or when the stage after it loads in the same cycle.
    logic [sqh_pkg::NST-1:0] vld_reg, vld_next, adv;

    always_comb begin
        adv[sqh_pkg::NST-1] = !vld_reg[sqh_pkg::NST-1] || m_tready;
        for (int i = sqh_pkg::NST-2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = adv[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < sqh_pkg::NST; i++) begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];

    // Stage 0: corner differences.
    sqh_pkg::dif_t dif_reg, dif_next;
    always_comb begin
        logic signed [CW-1:0] x00, y00, x10, y10, x01, y01, x11, y11;
        x00 = s_tdata[0*CW +: CW];
        y00 = s_tdata[1*CW +: CW];
        x10 = s_tdata[2*CW +: CW];
        y10 = s_tdata[3*CW +: CW];
        x01 = s_tdata[4*CW +: CW];
        y01 = s_tdata[5*CW +: CW];
        x11 = s_tdata[6*CW +: CW];
        y11 = s_tdata[7*CW +: CW];
        dif_next.a = sqh_pkg::DW'(x10) - sqh_pkg::DW'(x11);
        dif_next.b = sqh_pkg::DW'(x01) - sqh_pkg::DW'(x11);
        dif_next.d = sqh_pkg::DW'(y10) - sqh_pkg::DW'(y11);
        dif_next.e = sqh_pkg::DW'(y01) - sqh_pkg::DW'(y11);
        dif_next.c = sqh_pkg::CDW'(x00) - sqh_pkg::CDW'(x01)
                   - sqh_pkg::CDW'(x10) + sqh_pkg::CDW'(x11);
        dif_next.f = sqh_pkg::CDW'(y00) - sqh_pkg::CDW'(y01)
                   - sqh_pkg::CDW'(y10) + sqh_pkg::CDW'(y11);
        dif_next.cor.x00 = x00;
        dif_next.cor.y00 = y00;
        dif_next.cor.x10 = x10;
        dif_next.cor.y10 = y10;
        dif_next.cor.x01 = x01;
        dif_next.cor.y01 = y01;
    end

    // Stage 1: the six cross products.
    sqh_pkg::prd_t prd_reg, prd_next;
    always_comb begin
        prd_next.bd  = sqh_pkg::PW'(dif_reg.b) * sqh_pkg::PW'(dif_reg.d);
        prd_next.ae  = sqh_pkg::PW'(dif_reg.a) * sqh_pkg::PW'(dif_reg.e);
        prd_next.cd  = sqh_pkg::PW'(dif_reg.c) * sqh_pkg::PW'(dif_reg.d);
        prd_next.af  = sqh_pkg::PW'(dif_reg.a) * sqh_pkg::PW'(dif_reg.f);
        prd_next.bf  = sqh_pkg::PW'(dif_reg.b) * sqh_pkg::PW'(dif_reg.f);
        prd_next.ce  = sqh_pkg::PW'(dif_reg.c) * sqh_pkg::PW'(dif_reg.e);
        prd_next.cor = dif_reg.cor;
    end

    // Stage 2: determinant and the two numerators.
    sqh_pkg::num_t num_reg, num_next;
    always_comb begin
        num_next.det = sqh_pkg::NW'(prd_reg.bd) - sqh_pkg::NW'(prd_reg.ae);
        num_next.n32 = sqh_pkg::NW'(prd_reg.cd) - sqh_pkg::NW'(prd_reg.af);
        num_next.n31 = sqh_pkg::NW'(prd_reg.bf) - sqh_pkg::NW'(prd_reg.ce);
        num_next.cor = prd_reg.cor;
    end

    // Stage 3: magnitudes and the range check. A quotient of 2^32 or more in
    // magnitude saturates anyway, so the divider only resolves the low 32 bits.
    sqh_pkg::div_t prep_reg, prep_next;
    always_comb begin
        logic [sqh_pkg::NW-1:0] m32, m31;
        logic [sqh_pkg::RW-1:0] dsh;
        m32 = num_reg.n32[sqh_pkg::NW-1] ? sqh_pkg::NW'(-num_reg.n32) : num_reg.n32;
        m31 = num_reg.n31[sqh_pkg::NW-1] ? sqh_pkg::NW'(-num_reg.n31) : num_reg.n31;
        prep_next.dmag  = num_reg.det[sqh_pkg::NW-1] ? sqh_pkg::NW'(-num_reg.det)
                                                     : num_reg.det;
        prep_next.rem32 = sqh_pkg::RW'(m32) << sqh_pkg::FB;
        prep_next.rem31 = sqh_pkg::RW'(m31) << sqh_pkg::FB;
        dsh             = sqh_pkg::RW'(prep_next.dmag) << sqh_pkg::QB;
        prep_next.big32 = prep_next.rem32 >= dsh;
        prep_next.big31 = prep_next.rem31 >= dsh;
        prep_next.neg32 = num_reg.n32[sqh_pkg::NW-1] ^ num_reg.det[sqh_pkg::NW-1];
        prep_next.neg31 = num_reg.n31[sqh_pkg::NW-1] ^ num_reg.det[sqh_pkg::NW-1];
        prep_next.degen = num_reg.det == '0;
        prep_next.q32   = '0;
        prep_next.q31   = '0;
        prep_next.cor   = num_reg.cor;
    end

    // Stages 4 to 35: restoring division, one quotient bit per stage for each
    // of the two numerators against the shared determinant.
    sqh_pkg::div_t div_reg [sqh_pkg::QB];
    sqh_pkg::div_t div_next [sqh_pkg::QB];
    always_comb begin
        for (int k = 0; k < sqh_pkg::QB; k++) begin
            sqh_pkg::div_t          src;
            logic [sqh_pkg::RW-1:0] sh;
            src = (k == 0) ? prep_reg : div_reg[(k == 0) ? 0 : k-1];
            sh  = sqh_pkg::RW'(src.dmag) << (sqh_pkg::QB - 1 - k);
            div_next[k] = src;
            if (src.rem32 >= sh) begin
                div_next[k].rem32 = src.rem32 - sh;
                div_next[k].q32[sqh_pkg::QB-1-k] = 1'b1;
            end
            if (src.rem31 >= sh) begin
                div_next[k].rem31 = src.rem31 - sh;
                div_next[k].q31[sqh_pkg::QB-1-k] = 1'b1;
            end
        end
    end

    // Stage 36: sign and saturation of the perspective terms.
    function automatic logic [CW:0] sat_quot(input logic [CW-1:0] q, input logic neg,
                                             input logic big);
        logic [CW:0] r;
        if (!neg) begin
            if (big || q[CW-1]) r = {1'b1, 1'b0, {(CW-1){1'b1}}};
            else                r = {1'b0, q};
        end else begin
            if (big || (q[CW-1] && |q[CW-2:0])) r = {1'b1, 1'b1, {(CW-1){1'b0}}};
            else                                r = {1'b0, CW'(-q)};
        end
        return r;
    endfunction

    sqh_pkg::hsat_t hs_reg, hs_next;
    always_comb begin
        logic [CW:0] r32, r31;
        r32 = sat_quot(div_reg[sqh_pkg::QB-1].q32, div_reg[sqh_pkg::QB-1].neg32,
                       div_reg[sqh_pkg::QB-1].big32);
        r31 = sat_quot(div_reg[sqh_pkg::QB-1].q31, div_reg[sqh_pkg::QB-1].neg31,
                       div_reg[sqh_pkg::QB-1].big31);
        hs_next.h32   = r32[CW-1:0];
        hs_next.h31   = r31[CW-1:0];
        hs_next.ovf   = r32[CW] || r31[CW];
        hs_next.degen = div_reg[sqh_pkg::QB-1].degen;
        hs_next.cor   = div_reg[sqh_pkg::QB-1].cor;
    end

    // Stage 37: perspective terms times the far corners.
    sqh_pkg::hmul_t hm_reg, hm_next;
    always_comb begin
        hm_next.p11   = sqh_pkg::MW'(hs_reg.h31) * sqh_pkg::MW'(hs_reg.cor.x10);
        hm_next.p12   = sqh_pkg::MW'(hs_reg.h32) * sqh_pkg::MW'(hs_reg.cor.x01);
        hm_next.p21   = sqh_pkg::MW'(hs_reg.h31) * sqh_pkg::MW'(hs_reg.cor.y10);
        hm_next.p22   = sqh_pkg::MW'(hs_reg.h32) * sqh_pkg::MW'(hs_reg.cor.y01);
        hm_next.h31   = hs_reg.h31;
        hm_next.h32   = hs_reg.h32;
        hm_next.ovf   = hs_reg.ovf;
        hm_next.degen = hs_reg.degen;
        hm_next.cor   = hs_reg.cor;
    end

    // Stage 38: rescale toward zero and add the edge vectors.
    function automatic logic signed [sqh_pkg::SW-1:0] rescale_add(
        input logic signed [sqh_pkg::MW-1:0] p, input logic signed [CW-1:0] hi,
        input logic signed [CW-1:0] lo);
        logic signed [sqh_pkg::MW-1:0] pr;
        logic signed [sqh_pkg::SW-1:0] t;
        pr = p + (p[sqh_pkg::MW-1] ? sqh_pkg::MW'((1 << sqh_pkg::FB) - 1) : '0);
        t  = sqh_pkg::SW'(pr >>> sqh_pkg::FB);
        return t + sqh_pkg::SW'(hi) - sqh_pkg::SW'(lo);
    endfunction

    sqh_pkg::hsum_t hsum_reg, hsum_next;
    always_comb begin
        hsum_next.s11   = rescale_add(hm_reg.p11, hm_reg.cor.x10, hm_reg.cor.x00);
        hsum_next.s12   = rescale_add(hm_reg.p12, hm_reg.cor.x01, hm_reg.cor.x00);
        hsum_next.s21   = rescale_add(hm_reg.p21, hm_reg.cor.y10, hm_reg.cor.y00);
        hsum_next.s22   = rescale_add(hm_reg.p22, hm_reg.cor.y01, hm_reg.cor.y00);
        hsum_next.h31   = hm_reg.h31;
        hsum_next.h32   = hm_reg.h32;
        hsum_next.ovf   = hm_reg.ovf;
        hsum_next.degen = hm_reg.degen;
        hsum_next.cor   = hm_reg.cor;
    end

    // Stage 39: saturate the linear terms; a zero determinant zeroes all eight coefficients.
    function automatic logic [CW:0] sat_sum(input logic signed [sqh_pkg::SW-1:0] s);
        logic [CW:0]                   r;
        logic signed [sqh_pkg::SW-1:0] hi_lim;
        logic signed [sqh_pkg::SW-1:0] lo_lim;
        hi_lim = sqh_pkg::SW'(32'sh7fffffff);
        lo_lim = -hi_lim - sqh_pkg::SW'(1);
        if (s > hi_lim) begin
            r = {1'b1, 1'b0, {(CW-1){1'b1}}};
        end else if (s < lo_lim) begin
            r = {1'b1, 1'b1, {(CW-1){1'b0}}};
        end else begin
            r = {1'b0, s[CW-1:0]};
        end
        return r;
    endfunction

    logic [255:0] out_data_reg, out_data_next;
    logic [1:0]   out_user_reg, out_user_next;
    always_comb begin
        logic [CW:0] r11, r12, r21, r22;
        r11 = sat_sum(hsum_reg.s11);
        r12 = sat_sum(hsum_reg.s12);
        r21 = sat_sum(hsum_reg.s21);
        r22 = sat_sum(hsum_reg.s22);
        if (hsum_reg.degen) begin
            out_data_next = '0;
            out_user_next = 2'b01;
        end else begin
            out_data_next = {hsum_reg.h32, hsum_reg.h31, hsum_reg.cor.y00, r22[CW-1:0],
                             r21[CW-1:0], hsum_reg.cor.x00, r12[CW-1:0], r11[CW-1:0]};
            out_user_next = {hsum_reg.ovf || r11[CW] || r12[CW] || r21[CW] || r22[CW],
                             1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) dif_reg <= dif_next;
        if (adv[1]) prd_reg <= prd_next;
        if (adv[2]) num_reg <= num_next;
        if (adv[3]) prep_reg <= prep_next;
        for (int k = 0; k < sqh_pkg::QB; k++) begin
            if (adv[sqh_pkg::DIV0 + k]) div_reg[k] <= div_next[k];
        end
        if (adv[sqh_pkg::NST-4]) hs_reg <= hs_next;
        if (adv[sqh_pkg::NST-3]) hm_reg <= hm_next;
        if (adv[sqh_pkg::NST-2]) hsum_reg <= hsum_next;
        if (adv[sqh_pkg::NST-1]) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = vld_reg[sqh_pkg::NST-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // A degenerate result carries all-zero coefficients and no overflow.
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("degenerate result with nonzero payload");

    // An accepted item occupies the first stage in the next cycle.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item lost at pipeline entry");

    // An empty output stage never blocks the input.
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[sqh_pkg::NST-1] |-> s_tready)
        else $error("input stalled with free output stage");

    // A stalled output stage keeps its item in the next cycle.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[sqh_pkg::NST-1] && !m_tready |=> vld_reg[sqh_pkg::NST-1])
        else $error("output item dropped while stalled");
endmodule
`default_nettype wire
